// ----- src/clpul_pkg.sv -----
// Shared types and constants for the closest lattice point unit.
// Used by the sequencer top level and the shared multiply/divide unit.
// No dependencies.
package clpul_pkg;

    localparam int MAX_TERMS_DEF   = 48;
    localparam int VALUE_WIDTH_DEF = 31;

    // Datapath width of the shared unit and of all convergent values.
    localparam int ARITH_W = 64;

    // Saturated line differences lie in [-2^40, 2^40].
    localparam int DIFF_W = 42;
    localparam logic signed [ARITH_W-1:0] DIFF_SAT = 64'sh0000_0100_0000_0000;

    localparam int STEP_CAP = 64;
    localparam int STEP_W   = 7;

    // Step count t is clamped to [0, 2^31].
    localparam int T_W = 32;
    localparam logic [T_W-1:0] T_MAX = 32'h8000_0000;

    localparam int X_W = 31;
    localparam int Y_W = 62;

    // Seed convergents p/q at indexes 0 and 1.
    localparam logic [ARITH_W-1:0] SEED_NUM0 = 64'd0;
    localparam logic [ARITH_W-1:0] SEED_NUM1 = 64'd1;
    localparam logic [ARITH_W-1:0] SEED_DEN0 = 64'd1;
    localparam logic [ARITH_W-1:0] SEED_DEN1 = 64'd0;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV
    } t_arith_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_DIV_SHORT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_INIT,
        S_EU_CHECK,
        S_EU_DIV,
        S_EU_MP,
        S_EU_MQ,
        S_PH_DIV,
        S_WK_CHECK,
        S_RD_M,
        S_RD_I,
        S_RD_N,
        S_RD_L,
        S_DI_CHK,
        S_ST_CHECK,
        S_ST_CMP,
        S_ST_T,
        S_ST_DP,
        S_ST_DQ,
        S_ST_K,
        S_ST_DD,
        S_ST_D0,
        S_ST_LIM,
        S_ST_UQ,
        S_ST_UP,
        S_LD_CY,
        S_LD_AX,
        S_FINISH
    } t_seq_state;

endpackage

// ----- src/clpul_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module clpul_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/clpul_arith.sv -----
// Shared iterative unit: shift-add multiplier (mod 2^64) and restoring divider.
// Depends on clpul_pkg.
module clpul_arith #(
    parameter int VALUE_WIDTH = clpul_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  clpul_pkg::t_arith_req            i_req,
    input  logic [clpul_pkg::ARITH_W-1:0]    i_opa,
    input  logic [clpul_pkg::ARITH_W-1:0]    i_opb,
    output logic                             o_done,
    output logic [clpul_pkg::ARITH_W-1:0]    o_acc,
    output logic [clpul_pkg::ARITH_W-1:0]    o_quo
);

    localparam int W     = clpul_pkg::ARITH_W;
    localparam int CNT_W = $clog2(W + 1);

    clpul_pkg::t_arith_state r_state, n_state;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_mc, n_mc;
    logic [W-1:0]     r_mp, n_mp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;

    // In a division r_acc is the partial remainder, r_mc the dividend that
    // turns into the quotient and r_mp the divisor.
    assign rem_sh  = {r_acc, r_mc[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_mp};

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_mc    = r_mc;
        n_mp    = r_mp;
        n_cnt   = r_cnt;
        o_done  = 1'b0;
        unique case (r_state)
            clpul_pkg::AR_IDLE: begin
                if (i_req.start) begin
                    n_acc = '0;
                    n_mp  = i_opb;
                    unique case (i_req.op)
                        clpul_pkg::OP_MUL: begin
                            n_mc    = i_opa;
                            n_state = clpul_pkg::AR_MUL;
                        end
                        clpul_pkg::OP_DIV: begin
                            n_mc    = i_opa;
                            n_cnt   = CNT_W'(W);
                            n_state = clpul_pkg::AR_DIV;
                        end
                        clpul_pkg::OP_DIV_SHORT: begin
                            // Narrow dividend: skip its known leading zeros.
                            n_mc    = i_opa << (W - VALUE_WIDTH);
                            n_cnt   = CNT_W'(VALUE_WIDTH);
                            n_state = clpul_pkg::AR_DIV;
                        end
                        default: begin
                            n_state = clpul_pkg::AR_IDLE;
                        end
                    endcase
                end
            end
            clpul_pkg::AR_MUL: begin
                if (r_mp == '0) begin
                    o_done  = 1'b1;
                    n_state = clpul_pkg::AR_IDLE;
                end else begin
                    if (r_mp[0]) begin
                        n_acc = r_acc + r_mc;
                    end
                    n_mc = {r_mc[W-2:0], 1'b0};
                    n_mp = {1'b0, r_mp[W-1:1]};
                end
            end
            clpul_pkg::AR_DIV: begin
                if (r_cnt == '0) begin
                    o_done  = 1'b1;
                    n_state = clpul_pkg::AR_IDLE;
                end else begin
                    if (!rem_sub[W]) begin
                        n_acc = rem_sub[W-1:0];
                        n_mc  = {r_mc[W-2:0], 1'b1};
                    end else begin
                        n_acc = rem_sh[W-1:0];
                        n_mc  = {r_mc[W-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: begin
                n_state = clpul_pkg::AR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clpul_pkg::AR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
        r_cnt <= n_cnt;
    end

    assign o_acc = r_acc;
    assign o_quo = r_mc;

endmodule

// ----- src/closest_lattice_point_under_line_unit.sv -----
// Top level: sequencer, convergent store and output register of the unit.
// Depends on clpul_pkg, clpul_arith and clpul_ram.
//
// Usage. A request beat (action, A, B, C, N) is taken on the input channel
// when i_valid is high and o_stall is low. o_stall is high from the cycle
// after acceptance until the sequencer has finished, so one request is in
// work at a time. The single result beat (x, y, status) is held in an output
// register with o_valid until the receiver takes it with i_stall low; a new
// request may be accepted while that result still waits.
// Every multiply and divide runs on one shared unit. A Euclid term costs a
// VALUE_WIDTH-bit division plus two shift-add multiplies (each iterating
// over the significant bits of the quotient term); each walk step costs up
// to four line evaluations (two multiplies each), three full-width 64-bit
// divisions and four multiplies. A request with a zero divisor goes straight
// from the preparation state to the finish state.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any pending result. A stalled receiver only holds the result register;
// the next request still runs and waits in its final state until the output
// register is free.
module closest_lattice_point_under_line_unit #(
    parameter int MAX_TERMS   = clpul_pkg::MAX_TERMS_DEF,
    parameter int VALUE_WIDTH = clpul_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [VALUE_WIDTH-1:0]       i_coefficient_a,
    input  logic [VALUE_WIDTH-1:0]       i_offset_b,
    input  logic [VALUE_WIDTH-1:0]       i_divisor_c,
    input  logic [VALUE_WIDTH-1:0]       i_limit_n,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [clpul_pkg::X_W-1:0]    o_result_x,
    output logic [clpul_pkg::Y_W-1:0]    o_result_y,
    output logic                         o_status
);

    localparam int W      = clpul_pkg::ARITH_W;
    localparam int VW     = VALUE_WIDTH;
    localparam int DW     = clpul_pkg::DIFF_W;
    localparam int TW     = clpul_pkg::T_W;
    localparam int SW     = clpul_pkg::STEP_W;
    localparam int DEPTH  = MAX_TERMS + 2;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_TERMS + 4);

    // C*y - A*x modulo 2^64, read as signed and saturated to +-2^40.
    function automatic logic signed [DW-1:0] sat_diff(input logic [W-1:0] u);
        logic signed [W-1:0] s;
        logic signed [W-1:0] c;
        s = $signed(u);
        c = s;
        if (s > clpul_pkg::DIFF_SAT) begin
            c = clpul_pkg::DIFF_SAT;
        end else if (s < -clpul_pkg::DIFF_SAT) begin
            c = -clpul_pkg::DIFF_SAT;
        end
        return c[DW-1:0];
    endfunction

    clpul_pkg::t_seq_state r_state, n_state;
    clpul_pkg::t_seq_state r_ret, n_ret;
    logic r_issued, n_issued;
    logic r_act, n_act;
    logic r_st, n_st;
    logic [VW-1:0] r_a, n_a;
    logic [VW-1:0] r_b, n_b;
    logic [VW-1:0] r_c, n_c;
    logic [VW-1:0] r_n, n_n;
    logic [VW-1:0] r_lim, n_lim;
    logic [VW-1:0] r_num, n_num;
    logic [VW-1:0] r_den, n_den;
    logic [VW-1:0] r_term, n_term;
    logic [VW-1:0] r_rnext, n_rnext;
    logic [W-1:0] r_p1, n_p1;
    logic [W-1:0] r_p2, n_p2;
    logic [W-1:0] r_q1, n_q1;
    logic [W-1:0] r_q2, n_q2;
    logic [W-1:0] r_pn, n_pn;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [W-1:0] r_cpm, n_cpm;
    logic [W-1:0] r_cqm, n_cqm;
    logic [W-1:0] r_cpi, n_cpi;
    logic [W-1:0] r_cqi, n_cqi;
    logic [W-1:0] r_cpn, n_cpn;
    logic [W-1:0] r_cqn, n_cqn;
    logic [W-1:0] r_qh, n_qh;
    logic [W-1:0] r_ph, n_ph;
    logic signed [DW-1:0] r_di, n_di;
    logic signed [DW-1:0] r_dd, n_dd;
    logic signed [DW-1:0] r_d0, n_d0;
    logic signed [DW-1:0] r_diff, n_diff;
    logic [SW-1:0] r_steps, n_steps;
    logic [TW-1:0] r_t, n_t;
    logic [W-1:0] r_dp, n_dp;
    logic [W-1:0] r_dq, n_dq;
    logic [W-1:0] r_k, n_k;
    logic [W-1:0] r_ldx, n_ldx;
    logic [W-1:0] r_ldy, n_ldy;
    logic [W-1:0] r_prod, n_prod;
    logic r_out_valid, n_out_valid;
    logic [clpul_pkg::X_W-1:0] r_out_x, n_out_x;
    logic [clpul_pkg::Y_W-1:0] r_out_y, n_out_y;
    logic r_out_st, n_out_st;

    clpul_pkg::t_arith_req ar_req;
    logic [W-1:0] ar_opa, ar_opb, ar_acc, ar_quo;
    logic ar_done, op_state, op_done;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [2*W-1:0] ram_wdata, ram_rdata;

    logic [W-1:0] a_ext, c_ext, n_ext, b_ext, num_ext, den_ext, term_ext, t_ext;
    logic [W-1:0] eu_nq, dq_new, n_minus_qh, x_full;
    logic [CW-1:0] i_m, i_n, i_next;
    logic [CW:0] i_plus1;
    logic signed [DW:0] bs_s, xprime, bsd0;
    logic [DW:0] xabs, q_lo;
    logic signed [DW-1:0] ndi_s;
    logic signed [DW+1:0] t_raw;
    logic [TW-1:0] t_clamped;
    logic [W-1:0] k_new;

    assign a_ext    = {{(W-VW){1'b0}}, r_a};
    assign c_ext    = {{(W-VW){1'b0}}, r_c};
    assign n_ext    = {{(W-VW){1'b0}}, r_n};
    assign b_ext    = {{(W-VW){1'b0}}, r_b};
    assign num_ext  = {{(W-VW){1'b0}}, r_num};
    assign den_ext  = {{(W-VW){1'b0}}, r_den};
    assign term_ext = {{(W-VW){1'b0}}, r_term};
    assign t_ext    = {{(W-TW){1'b0}}, r_t};

    assign eu_nq      = ar_acc + r_q2;
    assign dq_new     = r_cqm + ar_acc;
    assign n_minus_qh = n_ext - r_qh;
    assign x_full     = {{(W-VW){1'b0}}, r_lim} - r_qh;

    assign i_m     = r_i - CW'(1);
    assign i_n     = r_i + CW'(1);
    assign i_next  = r_i + CW'(2);
    assign i_plus1 = {1'b0, r_i} + (CW+1)'(1);

    assign bs_s   = $signed({{(DW+1-VW){1'b0}}, r_b});
    assign xprime = r_diff - bs_s - $signed((DW+1)'(1));
    assign xabs   = xprime[DW] ? $unsigned(-xprime) : $unsigned(xprime);
    assign ndi_s  = -r_di;
    assign bsd0   = bs_s - r_d0;

    // t = 1 + x / (-di), with the quotient truncated towards zero.
    assign q_lo  = ar_quo[DW:0];
    assign t_raw = xprime[DW] ? $signed((DW+2)'(1)) - $signed({1'b0, q_lo})
                              : $signed((DW+2)'(1)) + $signed({1'b0, q_lo});

    always_comb begin
        if (t_raw[DW+1]) begin
            t_clamped = '0;
        end else if (t_raw > $signed({{(DW+2-TW){1'b0}}, clpul_pkg::T_MAX})) begin
            t_clamped = clpul_pkg::T_MAX;
        end else begin
            t_clamped = t_raw[TW-1:0];
        end
    end

    assign k_new   = (ar_quo < r_k) ? ar_quo : r_k;
    assign op_done = r_issued && ar_done;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_issued    = r_issued;
        n_act       = r_act;
        n_st        = r_st;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_n         = r_n;
        n_lim       = r_lim;
        n_num       = r_num;
        n_den       = r_den;
        n_term      = r_term;
        n_rnext     = r_rnext;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_q1        = r_q1;
        n_q2        = r_q2;
        n_pn        = r_pn;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_cpm       = r_cpm;
        n_cqm       = r_cqm;
        n_cpi       = r_cpi;
        n_cqi       = r_cqi;
        n_cpn       = r_cpn;
        n_cqn       = r_cqn;
        n_qh        = r_qh;
        n_ph        = r_ph;
        n_di        = r_di;
        n_dd        = r_dd;
        n_d0        = r_d0;
        n_diff      = r_diff;
        n_steps     = r_steps;
        n_t         = r_t;
        n_dp        = r_dp;
        n_dq        = r_dq;
        n_k         = r_k;
        n_ldx       = r_ldx;
        n_ldy       = r_ldy;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_st    = r_out_st;
        op_state    = 1'b0;
        ar_req.op   = clpul_pkg::OP_MUL;
        ar_opa      = '0;
        ar_opb      = '0;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt[AW-1:0];
        ram_wdata   = {r_pn, eu_nq};
        ram_raddr   = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            clpul_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_act   = i_action;
                    n_a     = i_coefficient_a;
                    n_b     = i_offset_b;
                    n_c     = i_divisor_c;
                    n_n     = i_limit_n;
                    n_state = clpul_pkg::S_PREP;
                end
            end
            clpul_pkg::S_PREP: begin
                n_qh = '0;
                n_ph = '0;
                if (!r_act) begin
                    n_st    = (r_c == '0);
                    n_state = (r_c == '0) ? clpul_pkg::S_FINISH : clpul_pkg::S_INIT;
                end else if (r_a == '0 || r_c == '0) begin
                    n_st    = 1'b1;
                    n_state = clpul_pkg::S_FINISH;
                end else begin
                    // The wrapper runs the walk with offset N mod A and limit N div A.
                    n_st      = 1'b0;
                    op_state  = 1'b1;
                    ar_req.op = clpul_pkg::OP_DIV_SHORT;
                    ar_opa    = n_ext;
                    ar_opb    = a_ext;
                    if (op_done) begin
                        n_lim   = ar_quo[VW-1:0];
                        n_n     = ar_quo[VW-1:0];
                        n_b     = ar_acc[VW-1:0];
                        n_state = clpul_pkg::S_INIT;
                    end
                end
            end
            clpul_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(1);
                ram_wdata = {clpul_pkg::SEED_NUM1, clpul_pkg::SEED_DEN1};
                n_num     = r_a;
                n_den     = r_c;
                n_p2      = clpul_pkg::SEED_NUM0;
                n_p1      = clpul_pkg::SEED_NUM1;
                n_q2      = clpul_pkg::SEED_DEN0;
                n_q1      = clpul_pkg::SEED_DEN1;
                n_cnt     = CW'(2);
                n_state   = clpul_pkg::S_EU_CHECK;
            end
            clpul_pkg::S_EU_CHECK: begin
                if (r_den != '0 && r_cnt < CW'(DEPTH)) begin
                    n_state = clpul_pkg::S_EU_DIV;
                end else begin
                    n_state = clpul_pkg::S_PH_DIV;
                end
            end
            clpul_pkg::S_EU_DIV: begin
                op_state  = 1'b1;
                ar_req.op = clpul_pkg::OP_DIV_SHORT;
                ar_opa    = num_ext;
                ar_opb    = den_ext;
                if (op_done) begin
                    n_term  = ar_quo[VW-1:0];
                    n_rnext = ar_acc[VW-1:0];
                    n_state = clpul_pkg::S_EU_MP;
                end
            end
            clpul_pkg::S_EU_MP: begin
                op_state = 1'b1;
                ar_opa   = r_p1;
                ar_opb   = term_ext;
                if (op_done) begin
                    n_pn    = ar_acc + r_p2;
                    n_state = clpul_pkg::S_EU_MQ;
                end
            end
            clpul_pkg::S_EU_MQ: begin
                op_state = 1'b1;
                ar_opa   = r_q1;
                ar_opb   = term_ext;
                if (op_done) begin
                    ram_we  = 1'b1;
                    n_p2    = r_p1;
                    n_p1    = r_pn;
                    n_q2    = r_q1;
                    n_q1    = eu_nq;
                    n_cnt   = r_cnt + CW'(1);
                    n_num   = r_den;
                    n_den   = r_rnext;
                    n_state = clpul_pkg::S_EU_CHECK;
                end
            end
            clpul_pkg::S_PH_DIV: begin
                op_state  = 1'b1;
                ar_req.op = clpul_pkg::OP_DIV_SHORT;
                ar_opa    = b_ext;
                ar_opb    = c_ext;
                if (op_done) begin
                    n_ph    = ar_quo;
                    n_i     = CW'(2);
                    n_state = clpul_pkg::S_WK_CHECK;
                end
            end
            clpul_pkg::S_WK_CHECK: begin
                if (i_plus1 < {1'b0, r_cnt}) begin
                    n_state = clpul_pkg::S_RD_M;
                end else begin
                    n_state = clpul_pkg::S_FINISH;
                end
            end
            clpul_pkg::S_RD_M: begin
                ram_raddr = i_m[AW-1:0];
                n_state   = clpul_pkg::S_RD_I;
            end
            clpul_pkg::S_RD_I: begin
                ram_raddr = r_i[AW-1:0];
                n_cpm     = ram_rdata[2*W-1:W];
                n_cqm     = ram_rdata[W-1:0];
                n_state   = clpul_pkg::S_RD_N;
            end
            clpul_pkg::S_RD_N: begin
                ram_raddr = i_n[AW-1:0];
                n_cpi     = ram_rdata[2*W-1:W];
                n_cqi     = ram_rdata[W-1:0];
                n_state   = clpul_pkg::S_RD_L;
            end
            clpul_pkg::S_RD_L: begin
                n_cpn   = ram_rdata[2*W-1:W];
                n_cqn   = ram_rdata[W-1:0];
                n_ldx   = r_cqi;
                n_ldy   = r_cpi;
                n_ret   = clpul_pkg::S_DI_CHK;
                n_state = clpul_pkg::S_LD_CY;
            end
            clpul_pkg::S_DI_CHK: begin
                n_di = r_diff;
                if (!r_diff[DW-1]) begin
                    n_i     = i_next;
                    n_state = clpul_pkg::S_WK_CHECK;
                end else begin
                    n_steps = '0;
                    n_state = clpul_pkg::S_ST_CHECK;
                end
            end
            clpul_pkg::S_ST_CHECK: begin
                if (r_steps < SW'(clpul_pkg::STEP_CAP)) begin
                    n_ldx   = r_qh + r_cqn;
                    n_ldy   = r_ph + r_cpn;
                    n_ret   = clpul_pkg::S_ST_CMP;
                    n_state = clpul_pkg::S_LD_CY;
                end else begin
                    n_i     = i_next;
                    n_state = clpul_pkg::S_WK_CHECK;
                end
            end
            clpul_pkg::S_ST_CMP: begin
                if (r_diff <= bs_s) begin
                    n_ldx   = r_qh + r_cqm;
                    n_ldy   = r_ph + r_cpm;
                    n_ret   = clpul_pkg::S_ST_T;
                    n_state = clpul_pkg::S_LD_CY;
                end else begin
                    n_i     = i_next;
                    n_state = clpul_pkg::S_WK_CHECK;
                end
            end
            clpul_pkg::S_ST_T: begin
                op_state  = 1'b1;
                ar_req.op = clpul_pkg::OP_DIV;
                ar_opa    = {{(W-DW-1){1'b0}}, xabs};
                ar_opb    = {{(W-DW){1'b0}}, ndi_s};
                if (op_done) begin
                    n_t     = t_clamped;
                    n_steps = r_steps + SW'(1);
                    n_state = clpul_pkg::S_ST_DP;
                end
            end
            clpul_pkg::S_ST_DP: begin
                op_state = 1'b1;
                ar_opa   = r_cpi;
                ar_opb   = t_ext;
                if (op_done) begin
                    n_dp    = r_cpm + ar_acc;
                    n_state = clpul_pkg::S_ST_DQ;
                end
            end
            clpul_pkg::S_ST_DQ: begin
                op_state = 1'b1;
                ar_opa   = r_cqi;
                ar_opb   = t_ext;
                if (op_done) begin
                    n_dq    = dq_new;
                    n_state = (dq_new == '0) ? clpul_pkg::S_FINISH : clpul_pkg::S_ST_K;
                end
            end
            clpul_pkg::S_ST_K: begin
                op_state  = 1'b1;
                ar_req.op = clpul_pkg::OP_DIV;
                ar_opa    = n_minus_qh;
                ar_opb    = r_dq;
                if (op_done) begin
                    n_k = ar_quo;
                    if (ar_quo == '0) begin
                        n_state = clpul_pkg::S_FINISH;
                    end else begin
                        n_ldx   = r_dq;
                        n_ldy   = r_dp;
                        n_ret   = clpul_pkg::S_ST_DD;
                        n_state = clpul_pkg::S_LD_CY;
                    end
                end
            end
            clpul_pkg::S_ST_DD: begin
                n_dd = r_diff;
                if (r_diff != '0) begin
                    n_ldx   = r_qh;
                    n_ldy   = r_ph;
                    n_ret   = clpul_pkg::S_ST_D0;
                    n_state = clpul_pkg::S_LD_CY;
                end else begin
                    n_state = clpul_pkg::S_ST_UQ;
                end
            end
            clpul_pkg::S_ST_D0: begin
                if (r_dd[DW-1] || r_diff > bs_s) begin
                    n_state = clpul_pkg::S_FINISH;
                end else begin
                    n_d0    = r_diff;
                    n_state = clpul_pkg::S_ST_LIM;
                end
            end
            clpul_pkg::S_ST_LIM: begin
                op_state  = 1'b1;
                ar_req.op = clpul_pkg::OP_DIV;
                ar_opa    = {{(W-DW-1){1'b0}}, $unsigned(bsd0)};
                ar_opb    = {{(W-DW){1'b0}}, $unsigned(r_dd)};
                if (op_done) begin
                    n_k     = k_new;
                    n_state = (k_new == '0) ? clpul_pkg::S_FINISH : clpul_pkg::S_ST_UQ;
                end
            end
            clpul_pkg::S_ST_UQ: begin
                op_state = 1'b1;
                ar_opa   = r_dq;
                ar_opb   = r_k;
                if (op_done) begin
                    n_qh    = r_qh + ar_acc;
                    n_state = clpul_pkg::S_ST_UP;
                end
            end
            clpul_pkg::S_ST_UP: begin
                op_state = 1'b1;
                ar_opa   = r_dp;
                ar_opb   = r_k;
                if (op_done) begin
                    n_ph    = r_ph + ar_acc;
                    n_state = clpul_pkg::S_ST_CHECK;
                end
            end
            clpul_pkg::S_LD_CY: begin
                op_state = 1'b1;
                ar_opa   = r_ldy;
                ar_opb   = c_ext;
                if (op_done) begin
                    n_prod  = ar_acc;
                    n_state = clpul_pkg::S_LD_AX;
                end
            end
            clpul_pkg::S_LD_AX: begin
                op_state = 1'b1;
                ar_opa   = r_ldx;
                ar_opb   = a_ext;
                if (op_done) begin
                    n_diff  = sat_diff(r_prod - ar_acc);
                    n_state = r_ret;
                end
            end
            clpul_pkg::S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_x     = (r_act && !r_st) ? x_full[clpul_pkg::X_W-1:0]
                                                   : r_qh[clpul_pkg::X_W-1:0];
                    n_out_y     = r_ph[clpul_pkg::Y_W-1:0];
                    n_out_st    = r_st;
                    n_state     = clpul_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clpul_pkg::S_IDLE;
            end
        endcase

        // Each arithmetic state starts the shared unit once and waits for it.
        ar_req.start = op_state && !r_issued;
        if (op_state && !r_issued) begin
            n_issued = 1'b1;
        end else if (op_done) begin
            n_issued = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clpul_pkg::S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_act    <= n_act;
        r_st     <= n_st;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_n      <= n_n;
        r_lim    <= n_lim;
        r_num    <= n_num;
        r_den    <= n_den;
        r_term   <= n_term;
        r_rnext  <= n_rnext;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_q1     <= n_q1;
        r_q2     <= n_q2;
        r_pn     <= n_pn;
        r_cnt    <= n_cnt;
        r_i      <= n_i;
        r_cpm    <= n_cpm;
        r_cqm    <= n_cqm;
        r_cpi    <= n_cpi;
        r_cqi    <= n_cqi;
        r_cpn    <= n_cpn;
        r_cqn    <= n_cqn;
        r_qh     <= n_qh;
        r_ph     <= n_ph;
        r_di     <= n_di;
        r_dd     <= n_dd;
        r_d0     <= n_d0;
        r_diff   <= n_diff;
        r_steps  <= n_steps;
        r_t      <= n_t;
        r_dp     <= n_dp;
        r_dq     <= n_dq;
        r_k      <= n_k;
        r_ldx    <= n_ldx;
        r_ldy    <= n_ldy;
        r_prod   <= n_prod;
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_out_st <= n_out_st;
    end

    clpul_arith #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ar_req),
        .i_opa  (ar_opa),
        .i_opb  (ar_opb),
        .o_done (ar_done),
        .o_acc  (ar_acc),
        .o_quo  (ar_quo)
    );

    clpul_ram #(
        .WIDTH(2 * W),
        .DEPTH(DEPTH)
    ) u_conv_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_stall    = (r_state != clpul_pkg::S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_result_x = r_out_x;
    assign o_result_y = r_out_y;
    assign o_status   = r_out_st;

endmodule

// ----- test/clpul_checker.sv -----
`timescale 1ns / 1ps
// Checker for the closest lattice point unit: watches both channels, predicts each result.
// Depends on clpul_pkg for the result widths, the term cap and the step cap.
module clpul_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_action,
    input  logic [30:0]                   i_coefficient_a,
    input  logic [30:0]                   i_offset_b,
    input  logic [30:0]                   i_divisor_c,
    input  logic [30:0]                   i_limit_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [clpul_pkg::X_W-1:0]     i_result_x,
    input  logic [clpul_pkg::Y_W-1:0]     i_result_y,
    input  logic                          i_status,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results
);

    localparam int TERM_CAP = clpul_pkg::MAX_TERMS_DEF;
    localparam longint SAT = 64'sd1 << 40;

    typedef struct packed {
        logic [clpul_pkg::X_W-1:0] x;
        logic [clpul_pkg::Y_W-1:0] y;
        logic                      status;
    } t_point;

    t_point expected_points[$];

    // C*y - A*x taken modulo 2^64 and saturated to +-2^40.
    function automatic longint line_gap(longint unsigned c, longint unsigned a,
                                        longint unsigned x, longint unsigned y);
        longint s;
        s = longint'(c * y - a * x);
        if (s > SAT) s = SAT;
        if (s < -SAT) s = -SAT;
        return s;
    endfunction

    function automatic void lattice_walk(longint unsigned a, longint unsigned b,
                                         longint unsigned c, longint unsigned n,
                                         output longint unsigned ox,
                                         output longint unsigned oy);
        longint unsigned cp[TERM_CAP+2];
        longint unsigned cq[TERM_CAP+2];
        longint unsigned num, den, qh, ph, term, r, dp, dq, k, lim;
        longint bs, di, gx, t, dd, d0;
        int cnt, i, steps;
        bit stop;
        num = a; den = c; qh = 0; bs = longint'(b); cnt = 2; stop = 0;
        cp[0] = 0; cp[1] = 1; cq[0] = 1; cq[1] = 0;
        while (den != 0 && cnt < TERM_CAP + 2) begin
            term = num / den;
            r = num % den;
            cp[cnt] = cp[cnt-1] * term + cp[cnt-2];
            cq[cnt] = cq[cnt-1] * term + cq[cnt-2];
            cnt++;
            num = den;
            den = r;
        end
        ph = b / c;
        for (i = 2; i + 1 < cnt && !stop; i += 2) begin
            di = line_gap(c, a, cq[i], cp[i]);
            steps = 0;
            if (di >= 0) continue;
            while (!stop && steps < clpul_pkg::STEP_CAP &&
                   line_gap(c, a, qh + cq[i+1], ph + cp[i+1]) <= bs) begin
                gx = line_gap(c, a, qh + cq[i-1], ph + cp[i-1]) - bs - 1;
                t = 1 + gx / (-di);
                steps++;
                if (t < 0) t = 0;
                if (t > (64'sd1 << 31)) t = 64'sd1 << 31;
                dp = cp[i-1] + longint'(t) * cp[i];
                dq = cq[i-1] + longint'(t) * cq[i];
                if (dq == 0) begin stop = 1; break; end
                k = (n - qh) / dq;
                if (k == 0) begin stop = 1; break; end
                dd = line_gap(c, a, dq, dp);
                if (dd != 0) begin
                    d0 = line_gap(c, a, qh, ph);
                    if (dd < 0 || d0 > bs) begin stop = 1; break; end
                    lim = longint'(bs - d0) / longint'(dd);
                    if (lim < k) k = lim;
                    if (k == 0) begin stop = 1; break; end
                end
                qh += k * dq;
                ph += k * dp;
            end
        end
        ox = qh;
        oy = ph;
    endfunction

    function automatic t_point predict_point(logic act, longint unsigned a,
                                             longint unsigned b, longint unsigned c,
                                             longint unsigned n);
        t_point p;
        longint unsigned x, y, lim;
        x = 0; y = 0; p.status = 0;
        if (act == 1'b0) begin
            if (c == 0) p.status = 1;
            else lattice_walk(a, b, c, n, x, y);
        end else begin
            if (a == 0 || c == 0) begin
                p.status = 1;
            end else begin
                lim = n / a;
                lattice_walk(a, n % a, c, lim, x, y);
                x = lim - x;
            end
        end
        p.x = x[clpul_pkg::X_W-1:0];
        p.y = y[clpul_pkg::Y_W-1:0];
        return p;
    endfunction

    assign o_pending = expected_points.size();

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (expected_points.size() == 0) begin
                    if (o_errors < 10)
                        $display("ERROR: unexpected result beat x=%0d y=%0d st=%0d",
                                 i_result_x, i_result_y, i_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (want !== {i_result_x, i_result_y, i_status}) begin
                        if (o_errors < 10)
                            $display("ERROR: expected x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                                     want.x, want.y, want.status,
                                     i_result_x, i_result_y, i_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_points = {expected_points,
                                   predict_point(i_action, i_coefficient_a, i_offset_b,
                                                 i_divisor_c, i_limit_n)};
        end
    end
endmodule

// ----- test/closest_lattice_point_under_line_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench top: drives requests into the closest lattice point unit and gives the verdict.
// Depends on the unit and clpul_checker, and through them on clpul_pkg.
module closest_lattice_point_under_line_unit_test;
    localparam int WATCHDOG = 400000;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, out_stall = 0;
    logic        action = 0;
    logic [30:0] coef_a = 0, off_b = 0, div_c = 0, lim_n = 0;
    wire         in_stall, out_valid, status;
    wire  [30:0] res_x;
    wire  [61:0] res_y;
    int          errors, pending, results, idle_cycles;
    bit          calm;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    closest_lattice_point_under_line_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_action(action), .i_coefficient_a(coef_a), .i_offset_b(off_b),
        .i_divisor_c(div_c), .i_limit_n(lim_n), .o_valid(out_valid), .i_stall(out_stall),
        .o_result_x(res_x), .o_result_y(res_y), .o_status(status)
    );

    clpul_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_action(action), .i_coefficient_a(coef_a), .i_offset_b(off_b),
        .i_divisor_c(div_c), .i_limit_n(lim_n), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_result_x(res_x), .i_result_y(res_y),
        .i_status(status), .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver stalls about a third of the time, except in calm stretches.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 34);
    end

    // Watchdog: cycles with no beat accepted on either channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("Watchdog expired with %0d results outstanding", pending);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [30:0] pick_value();
        case ($urandom_range(5))
            0: return 31'($urandom_range(3));
            1: return 31'($urandom_range(100));
            2: return 31'($urandom_range(100000));
            3: return 31'h7fff_ffff - 31'($urandom_range(3));
            default: return 31'($urandom());
        endcase
    endfunction

    // One request beat; gaps come beforehand so valid is never dropped and raised in one step.
    task automatic send_request(logic act, logic [30:0] a, b, c, n);
        while (!calm && $urandom_range(99) < 34) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        coef_a <= a;
        off_b <= b;
        div_c <= c;
        lim_n <= n;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        idle_cycles = 0;
        calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: zero divisors, extremes, both actions.
        send_request(0, 5, 7, 0, 10);
        send_request(1, 0, 7, 5, 10);
        send_request(1, 5, 7, 0, 10);
        send_request(0, 0, 0, 1, 0);
        send_request(0, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        send_request(1, 31'h7fff_ffff, 0, 31'h7fff_ffff, 31'h7fff_ffff);
        send_request(0, 3, 1, 7, 100);
        send_request(0, 1, 0, 31'h7fff_ffff, 31'h7fff_ffff);
        send_request(0, 31'h7fff_ffff, 5, 1, 31'h7fff_ffff);
        send_request(1, 1, 0, 1, 31'h7fff_ffff);
        send_request(1, 7, 0, 11, 1000);
        send_request(0, 1346269, 12345, 832040, 2000000);
        send_request(1, 832040, 0, 1346269, 31'h7fff_ffff);
        send_request(0, 31'h5555_5555, 31'h2aaa_aaaa, 31'h2aaa_aaab, 31'h5555_5555);
        // Hold off until the pipeline has drained completely.
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        for (int i = 0; i < 300; i++) begin
            calm = (i >= 120 && i < 160);
            send_request(1'($urandom_range(1)), pick_value(), pick_value(),
                         pick_value(), pick_value());
        end
        calm = 0;
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d results over both actions, zero divisors and extreme operands.",
                 results);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/clpul_pkg.sv
src/clpul_ram.sv
src/clpul_arith.sv
src/closest_lattice_point_under_line_unit.sv
test/clpul_checker.sv
test/closest_lattice_point_under_line_unit_test.sv
